FILE: hdl/assert_macros.svh
// assertion macros used by the timer scheduler top level
// depends on: nothing; users provide clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising edge outside reset
`define CTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define CTPS_ASSERT_NEVER(lbl, cond, msg) \
  `CTPS_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/ctps_pkg.sv
// types and constants of the control packet timer scheduler
// depends on: nothing
package ctps_pkg;

  // fixed timing constants, register reset values and the default queue depth
  localparam logic [31:0] MIN_NAK_INTERVAL    = 32'd20000;
  localparam logic [31:0] ACK_INTERVAL_RST    = 32'd10000;
  localparam logic [31:0] KEEPALIVE_RST       = 32'd1000000;
  localparam logic [31:0] LITE_ACK_PACKETS_RST = 32'd64;
  localparam int unsigned QUEUE_DEPTH         = 4;

  // event codes
  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_DATA    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_SENT    = 3'd3,
    OP_LOSS    = 3'd4,
    OP_POLL    = 3'd5
  } op_e;

  // action codes
  typedef enum logic [1:0] {
    ACT_FULL = 2'd0,
    ACT_LITE = 2'd1,
    ACT_NAK  = 2'd2,
    ACT_KEEP = 2'd3
  } act_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ACK_INTERVAL  = 2'd0,
    REG_KEEPALIVE     = 2'd1,
    REG_LITE_PACKETS  = 2'd2
  } reg_e;

  // input request
  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] now_time;
    logic        loss_present;
    logic [31:0] nak_interval_request;
    logic        defer_first_report;
  } ctps_in_t;

  // result request
  typedef struct packed {
    logic [1:0] action;
    logic       last_action;
  } ctps_out_t;

  // actions decided by one poll
  typedef struct packed {
    logic ack_en;
    logic ack_lite;
    logic nak_en;
    logic keep_en;
  } ctps_group_t;

  // configuration write
  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [31:0] data;
  } ctps_cfg_t;

endpackage

FILE: hdl/ctps_front.sv
// event front end: configuration, timer state and poll decisions
// depends on: ctps_pkg
module ctps_front
  import ctps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctps_cfg_t   cfg_i,
  input  logic        accept_i,
  input  ctps_in_t    item_i,
  output logic        grp_push_o,
  output ctps_group_t grp_o
);

  logic [31:0] ack_iv_q, keep_iv_q, lite_pk_q;
  logic [31:0] ack_iv, keep_iv, lite_iv;

  logic        ack_pending_q, ack_pending_d;
  logic [63:0] next_ack_q, next_ack_d;
  logic [63:0] next_nak_q, next_nak_d;
  logic [63:0] last_send_q, last_send_d;
  logic [31:0] nak_period_q, nak_period_d;
  logic        loss_q, loss_d;
  logic [31:0] pkts_q, pkts_d;
  logic [31:0] lite_thr_q, lite_thr_d;

  logic [63:0] now;
  logic        full_due, lite_due, nak_due, keep_due;
  logic [63:0] keep_sum, ack_sum, nak_sum, start_nak;
  logic [32:0] lite_sum;
  logic [31:0] lite_next;
  logic [31:0] nak_req;
  logic [64:0] defer_sum;
  logic [63:0] defer_time;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_iv_q  <= ACK_INTERVAL_RST;
      keep_iv_q <= KEEPALIVE_RST;
      lite_pk_q <= LITE_ACK_PACKETS_RST;
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        REG_ACK_INTERVAL: ack_iv_q  <= cfg_i.data;
        REG_KEEPALIVE:    keep_iv_q <= cfg_i.data;
        REG_LITE_PACKETS: lite_pk_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // intervals never below one
  assign ack_iv  = (ack_iv_q == '0) ? 32'd1 : ack_iv_q;
  assign keep_iv = (keep_iv_q == '0) ? 32'd1 : keep_iv_q;
  assign lite_iv = (lite_pk_q == '0) ? 32'd1 : lite_pk_q;

  // timer arithmetic, all in parallel
  assign now       = item_i.now_time;
  assign keep_sum  = last_send_q + {32'd0, keep_iv};
  assign ack_sum   = now + {32'd0, ack_iv};
  assign nak_sum   = now + {32'd0, nak_period_q};
  assign start_nak = now + {32'd0, MIN_NAK_INTERVAL};
  assign lite_sum  = {1'b0, lite_thr_q} + {1'b0, lite_iv};
  assign lite_next = lite_sum[32] ? '1 : lite_sum[31:0];
  assign nak_req   = (item_i.nak_interval_request < MIN_NAK_INTERVAL) ?
                     MIN_NAK_INTERVAL : item_i.nak_interval_request;
  assign defer_sum  = {1'b0, now} + {33'd0, nak_req};
  assign defer_time = defer_sum[64] ? '1 : defer_sum[63:0];

  // poll decisions
  assign full_due = ack_pending_q && (now >= next_ack_q);
  assign lite_due = ack_pending_q && !full_due && (pkts_q >= lite_thr_q);
  assign nak_due  = loss_q && (now >= next_nak_q);
  assign keep_due = now >= keep_sum;

  // next state per event
  always_comb begin
    ack_pending_d = ack_pending_q;
    next_ack_d    = next_ack_q;
    next_nak_d    = next_nak_q;
    last_send_d   = last_send_q;
    nak_period_d  = nak_period_q;
    loss_d        = loss_q;
    pkts_d        = pkts_q;
    lite_thr_d    = lite_thr_q;
    if (accept_i) begin
      case (item_i.operation)
        OP_START: begin
          ack_pending_d = 1'b0;
          next_ack_d    = ack_sum;
          next_nak_d    = start_nak;
          last_send_d   = now;
          nak_period_d  = MIN_NAK_INTERVAL;
          loss_d        = 1'b0;
          pkts_d        = '0;
          lite_thr_d    = lite_iv;
        end
        OP_DATA: begin
          ack_pending_d = 1'b1;
          if (pkts_q != '1) begin
            pkts_d = pkts_q + 32'd1;
          end
        end
        OP_RELEASE: begin
          ack_pending_d = 1'b1;
          if (now < next_ack_q) begin
            next_ack_d = now;
          end
        end
        OP_SENT: begin
          last_send_d = now;
        end
        OP_LOSS: begin
          nak_period_d = nak_req;
          if (item_i.loss_present && !loss_q) begin
            next_nak_d = item_i.defer_first_report ? defer_time : now;
          end
          loss_d = item_i.loss_present;
        end
        OP_POLL: begin
          if (full_due) begin
            ack_pending_d = 1'b0;
            pkts_d        = '0;
            lite_thr_d    = lite_iv;
            next_ack_d    = ack_sum;
          end else if (lite_due) begin
            lite_thr_d = lite_next;
          end
          if (nak_due) begin
            next_nak_d = nak_sum;
          end
          if (keep_due) begin
            last_send_d = now;
          end
        end
        default: ;
      endcase
    end
  end

  // timer state registers, reset acts as a start at time zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_pending_q <= 1'b0;
      next_ack_q    <= {32'd0, ACK_INTERVAL_RST};
      next_nak_q    <= {32'd0, MIN_NAK_INTERVAL};
      last_send_q   <= '0;
      nak_period_q  <= MIN_NAK_INTERVAL;
      loss_q        <= 1'b0;
      pkts_q        <= '0;
      lite_thr_q    <= LITE_ACK_PACKETS_RST;
    end else begin
      ack_pending_q <= ack_pending_d;
      next_ack_q    <= next_ack_d;
      next_nak_q    <= next_nak_d;
      last_send_q   <= last_send_d;
      nak_period_q  <= nak_period_d;
      loss_q        <= loss_d;
      pkts_q        <= pkts_d;
      lite_thr_q    <= lite_thr_d;
    end
  end

  // action group of a poll
  assign grp_o.ack_en   = full_due || lite_due;
  assign grp_o.ack_lite = lite_due;
  assign grp_o.nak_en   = nak_due;
  assign grp_o.keep_en  = keep_due;
  assign grp_push_o = accept_i && (item_i.operation == OP_POLL) &&
                      (grp_o.ack_en || nak_due || keep_due);

endmodule

FILE: hdl/ctps_fifo.sv
// small queue of poll action groups between front and back end
// depends on: ctps_pkg
module ctps_fifo
  import ctps_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ctps_group_t data_i,
  input  logic        pop_i,
  output ctps_group_t data_o,
  output logic        valid_o,
  output logic        full_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [IdxW-1:0] IdxOne  = IdxW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  ctps_group_t         mem_q [Depth];
  logic [IdxW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + IdxOne;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + IdxOne;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntOne;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntOne;
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == FullCnt;

endmodule

FILE: hdl/ctps_back.sv
// back end: issues the actions of one group, one result per cycle while pop is high
// depends on: ctps_pkg
module ctps_back
  import ctps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctps_group_t head_i,
  input  logic        head_valid_i,
  output logic        head_pop_o,
  output ctps_out_t   res_o,
  output logic        empty_o,
  input  logic        pop_i
);

  ctps_group_t grp_q, grp_d;
  logic        grp_any, grp_last;
  logic [1:0]  grp_cnt;

  assign grp_any = grp_q.ack_en || grp_q.nak_en || grp_q.keep_en;
  assign grp_cnt = {1'b0, grp_q.ack_en} + {1'b0, grp_q.nak_en} + {1'b0, grp_q.keep_en};
  assign grp_last = grp_cnt == 2'd1;

  // first remaining action of the current group: ACK, then NAK, then keepalive
  always_comb begin
    if (grp_q.ack_en) begin
      res_o.action = grp_q.ack_lite ? ACT_LITE : ACT_FULL;
    end else if (grp_q.nak_en) begin
      res_o.action = ACT_NAK;
    end else begin
      res_o.action = ACT_KEEP;
    end
  end
  assign res_o.last_action = grp_last;
  assign empty_o = !grp_any;

  // retire taken action, load next group without a gap
  always_comb begin
    grp_d = grp_q;
    if (pop_i && grp_any) begin
      if (grp_q.ack_en) begin
        grp_d.ack_en = 1'b0;
      end else if (grp_q.nak_en) begin
        grp_d.nak_en = 1'b0;
      end else begin
        grp_d.keep_en = 1'b0;
      end
    end
    head_pop_o = head_valid_i && (!grp_any || (pop_i && grp_last));
    if (head_pop_o) begin
      grp_d = head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else begin
      grp_q <= grp_d;
    end
  end

endmodule

FILE: hdl/control_packet_timer_scheduler_unit.sv
// Receiver control timer scheduler. An event request is taken in any cycle in which full is
// low, so events go in one per clock; the front end updates the ACK, loss report and
// keepalive timers in that same cycle. A poll that finds k actions due (1 to 3) places them
// as one group in a queue of QueueDepth groups (a poll with none places nothing), and the
// back end hands them out in order, one result per cycle while pop is high, with last_action
// set on the final one. The first action of a poll passes through the group queue and then
// the back end's group register before it can be taken, later when older groups are still
// waiting. A poll with k actions thus yields k results; full rises only while the group
// queue is full. Configuration writes take effect at the next event that uses the register.
`include "assert_macros.svh"

// top level: front end, group queue and back end
// depends on: ctps_pkg, ctps_front, ctps_fifo, ctps_back, assert_macros.svh
module control_packet_timer_scheduler_unit
  import ctps_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  ctps_in_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output ctps_out_t   res_o
);

  ctps_cfg_t   cfg;
  logic        accept;
  logic        q_push, q_pop, q_valid, q_full;
  ctps_group_t q_in, q_head;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  assign full   = q_full;
  assign accept = push && !q_full;

  // event handling and poll decisions
  ctps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .grp_push_o (q_push),
    .grp_o      (q_in)
  );

  // decoupling queue
  ctps_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // result issue
  ctps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .head_pop_o   (q_pop),
    .res_o        (res_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  // queue never written when full nor read when empty
  `CTPS_ASSERT_NEVER(a_no_overflow, q_push && q_full, "group queue overflow")
  `CTPS_ASSERT(a_no_underflow, q_pop |-> q_valid, "group queue underflow")
  // only an accepted poll yields a group
  `CTPS_ASSERT(a_push_on_poll, q_push |-> (accept && in_item_i.operation == OP_POLL),
               "group pushed without accepted poll")

endmodule

FILE: tb/sv/tb_control_packet_timer_scheduler_unit.sv
// testbench of control_packet_timer_scheduler_unit: timed events in, ACK/NAK/keepalive actions out
// a scoreboard class predicts the actions of every poll; depends on ctps_pkg and the unit
module tb_control_packet_timer_scheduler_unit;
  import ctps_pkg::*;

  localparam logic [2:0]  OP_SPARE_LO   = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam logic [63:0] TIME_MAX      = '1;
  localparam int          IDLE_PCT      = 28;
  localparam int          SETTLE_CYCLES = 12;

  // timer state mirror and queue of actions still owed by the unit
  class action_scoreboard;
    logic [31:0] ack_iv, keep_iv, lite_pk;
    bit          ack_due, in_loss;
    logic [63:0] ack_deadline, nak_deadline, last_tx;
    logic [31:0] nak_gap, rx_count, lite_mark;
    ctps_out_t   due_actions[$];
    int          fails;

    function new();
      ack_iv  = ACK_INTERVAL_RST;
      keep_iv = KEEPALIVE_RST;
      lite_pk = LITE_ACK_PACKETS_RST;
      fails   = 0;
      restart(64'd0);
    endfunction

    function logic [31:0] floor_one(logic [31:0] v);
      return (v == 32'd0) ? 32'd1 : v;
    endfunction

    function void restart(logic [63:0] now);
      ack_due      = 1'b0;
      ack_deadline = now + {32'd0, floor_one(ack_iv)};
      nak_deadline = now + {32'd0, MIN_NAK_INTERVAL};
      last_tx      = now;
      nak_gap      = MIN_NAK_INTERVAL;
      in_loss      = 1'b0;
      rx_count     = 32'd0;
      lite_mark    = floor_one(lite_pk);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ACK_INTERVAL: ack_iv = val;
        REG_KEEPALIVE:    keep_iv = val;
        REG_LITE_PACKETS: lite_pk = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_actions.size();
    endfunction

    // apply one accepted event; a poll queues the actions it should raise
    function void note_event(ctps_in_t ev);
      logic [63:0] now;
      logic [31:0] stride;
      act_e        acts[$];
      ctps_out_t   res;
      now = ev.now_time;
      case (ev.operation)
        OP_START: restart(now);
        OP_DATA: begin
          ack_due = 1'b1;
          if (rx_count != '1) rx_count++;
        end
        OP_RELEASE: begin
          ack_due = 1'b1;
          if (now < ack_deadline) ack_deadline = now;
        end
        OP_SENT: last_tx = now;
        OP_LOSS: begin
          nak_gap = (ev.nak_interval_request < MIN_NAK_INTERVAL) ? MIN_NAK_INTERVAL
                                                                 : ev.nak_interval_request;
          // onset only; a repeated loss keeps the running deadline
          if (ev.loss_present && !in_loss) begin
            if (!ev.defer_first_report) nak_deadline = now;
            else if (now > TIME_MAX - {32'd0, nak_gap}) nak_deadline = TIME_MAX;
            else nak_deadline = now + {32'd0, nak_gap};
          end
          in_loss = ev.loss_present;
        end
        OP_POLL: begin
          if (ack_due && now >= ack_deadline) begin
            acts.push_back(ACT_FULL);
            ack_due      = 1'b0;
            rx_count     = 32'd0;
            lite_mark    = floor_one(lite_pk);
            ack_deadline = now + {32'd0, floor_one(ack_iv)};
          end else if (ack_due && rx_count >= lite_mark) begin
            stride = floor_one(lite_pk);
            acts.push_back(ACT_LITE);
            lite_mark = (lite_mark > 32'hFFFF_FFFF - stride) ? '1 : lite_mark + stride;
          end
          if (in_loss && now >= nak_deadline) begin
            acts.push_back(ACT_NAK);
            nak_deadline = now + {32'd0, nak_gap};
          end
          if (now >= last_tx + {32'd0, floor_one(keep_iv)}) begin
            acts.push_back(ACT_KEEP);
            last_tx = now;
          end
          foreach (acts[k]) begin
            res.action      = acts[k];
            res.last_action = (k == acts.size() - 1);
            due_actions.push_back(res);
          end
        end
        default: ;
      endcase
    endfunction

    // compare one popped action with the oldest one owed
    function void check_action(ctps_out_t got);
      ctps_out_t want;
      if (due_actions.size() == 0) begin
        $display("%0t: unexpected action: expected none, actual action %0d last %0b",
                 $time, got.action, got.last_action);
        fails++;
        return;
      end
      want = due_actions.pop_front();
      if (got.action !== want.action) begin
        $display("%0t: action mismatch: expected %0d, actual %0d", $time, want.action,
                 got.action);
        fails++;
      end
      if (got.last_action !== want.last_action) begin
        $display("%0t: last_action mismatch: expected %0b, actual %0b", $time,
                 want.last_action, got.last_action);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        push, full, empty, pop;
  ctps_in_t    in_item_i;
  ctps_out_t   res_o;

  bit               calm;
  logic [63:0]      sim_now;
  action_scoreboard board = new();

  control_packet_timer_scheduler_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side stalls at random unless in a calm stretch
  always @(posedge clk_i) begin
    pop <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watch both handshakes on the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_event(in_item_i);
      if (pop && !empty) board.check_action(res_o);
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_event(ctps_in_t ev);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= ev;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_fields(logic [2:0] op, logic [63:0] now, logic loss, logic [31:0] req,
                             logic defer);
    ctps_in_t ev;
    ev.operation            = op;
    ev.now_time             = now;
    ev.loss_present         = loss;
    ev.nak_interval_request = req;
    ev.defer_first_report   = defer;
    send_event(ev);
  endtask

  // stop sending and wait until every owed action has come out
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic set_config(logic [31:0] ack, logic [31:0] keep, logic [31:0] lite,
                            bit with_spare);
    write_reg(REG_ACK_INTERVAL, ack);
    write_reg(REG_KEEPALIVE, keep);
    write_reg(REG_LITE_PACKETS, lite);
    if (with_spare) write_reg(REG_SPARE, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // mostly forward-moving time with occasional jumps, wraps and backward steps
  task automatic random_event(output ctps_in_t ev);
    int pick, span;
    pick = $urandom_range(99);
    span = $urandom_range(99);
    if (span < 55) sim_now += $urandom_range(0, 3000);
    else if (span < 85) sim_now += $urandom_range(0, 300000);
    else if (span < 93) sim_now += {$urandom, $urandom} >> $urandom_range(8, 63);
    else if (span < 97) sim_now = TIME_MAX - $urandom_range(0, 100000);
    else sim_now = {$urandom, $urandom};
    ev.now_time           = sim_now;
    ev.loss_present       = ($urandom_range(99) < 65);
    ev.defer_first_report = $urandom_range(1);
    case ($urandom_range(2))
      0:       ev.nak_interval_request = $urandom_range(0, MIN_NAK_INTERVAL);
      1:       ev.nak_interval_request = $urandom_range(20000, 400000);
      default: ev.nak_interval_request = $urandom;
    endcase
    if (pick < 3) ev.operation = OP_START;
    else if (pick < 28) ev.operation = OP_DATA;
    else if (pick < 38) ev.operation = OP_RELEASE;
    else if (pick < 48) ev.operation = OP_SENT;
    else if (pick < 58) ev.operation = OP_LOSS;
    else if (pick < 97) ev.operation = OP_POLL;
    else if (pick < 98) ev.operation = OP_SPARE_LO;
    else ev.operation = OP_SPARE_HI;
  endtask

  task automatic run_phase(int count);
    ctps_in_t ev;
    for (int i = 0; i < count; i++) begin
      random_event(ev);
      send_event(ev);
    end
    settle();
  endtask

  // main sequence
  initial begin
    push        <= 1'b0;
    pop         <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= REG_ACK_INTERVAL;
    cfg_data_i  <= 32'd0;
    in_item_i   <= '0;
    sim_now     = 64'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: each event kind, clamps, wrap and the saturated deferred report
    send_fields(OP_POLL, 64'd0, 1'b0, 32'd0, 1'b0);
    send_fields(OP_DATA, 64'd100, 1'b1, '1, 1'b1);
    send_fields(OP_DATA, 64'd200, 1'b0, 32'd0, 1'b0);
    send_fields(OP_RELEASE, 64'd5000, 1'b0, 32'd0, 1'b0);
    send_fields(OP_POLL, 64'd5000, 1'b0, 32'd0, 1'b0);
    send_fields(OP_SENT, 64'd6000, 1'b0, 32'd0, 1'b0);
    send_fields(OP_LOSS, 64'd6000, 1'b1, 32'd0, 1'b1);
    send_fields(OP_POLL, 64'd20000, 1'b0, 32'd0, 1'b0);
    send_fields(OP_POLL, 64'd26000, 1'b0, 32'd0, 1'b0);
    send_fields(OP_LOSS, 64'd27000, 1'b1, '1, 1'b0);
    send_fields(OP_LOSS, 64'd28000, 1'b0, 32'd19999, 1'b0);
    send_fields(OP_POLL, 64'd2000000, 1'b0, 32'd0, 1'b0);
    send_fields(OP_SPARE_LO, TIME_MAX, 1'b1, '1, 1'b1);
    send_fields(OP_SPARE_HI, 64'd0, 1'b0, 32'd0, 1'b0);
    send_fields(OP_LOSS, TIME_MAX - 64'd16, 1'b0, 32'd0, 1'b0);
    send_fields(OP_LOSS, TIME_MAX - 64'd16, 1'b1, '1, 1'b1);
    send_fields(OP_DATA, TIME_MAX - 64'd8, 1'b0, 32'd0, 1'b0);
    send_fields(OP_POLL, TIME_MAX, 1'b0, 32'd0, 1'b0);
    send_fields(OP_START, TIME_MAX, 1'b0, 32'd0, 1'b0);
    send_fields(OP_RELEASE, 64'd0, 1'b1, '1, 1'b1);
    send_fields(OP_POLL, 64'd0, 1'b0, 32'd0, 1'b0);
    send_fields(OP_START, 64'd0, 1'b0, 32'd0, 1'b0);
    send_fields(OP_POLL, 64'd50, 1'b0, 32'd0, 1'b0);
    settle();

    // zero registers clamp to one, plus a write to the unused index
    sim_now = 64'd0;
    set_config(32'd0, 32'd0, 32'd0, 1'b1);
    run_phase(35);

    set_config(32'd1, 32'd1, 32'd1, 1'b0);
    run_phase(35);

    set_config($urandom_range(2, 5000), $urandom_range(50, 80000), $urandom_range(1, 6), 1'b0);
    run_phase(40);

    set_config('1, '1, '1, 1'b0);
    run_phase(35);

    // a stretch with no idling on either side
    calm = 1'b1;
    set_config($urandom_range(2, 5000), $urandom_range(50, 80000), $urandom_range(1, 6), 1'b1);
    run_phase(40);
    calm = 1'b0;

    if (board.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: control_packet_timer_scheduler_unit.f
+incdir+hdl
hdl/ctps_pkg.sv
hdl/ctps_front.sv
hdl/ctps_fifo.sv
hdl/ctps_back.sv
hdl/control_packet_timer_scheduler_unit.sv
tb/sv/tb_control_packet_timer_scheduler_unit.sv
